// File: hdl/hpr_pkg.sv
// ----------------------------------------------------------------------------
// hpr_pkg
// Shared types, constants and the microcode table of the Horner polynomial
// root check.
// ----------------------------------------------------------------------------
package hpr_pkg;

  localparam int unsigned COEFF_COUNT = 16;
  localparam int unsigned CIDX_W      = (COEFF_COUNT > 1) ? $clog2(COEFF_COUNT) : 1;
  localparam int unsigned UPC_W       = 3;
  localparam int unsigned ADDR_W      = 3;

  localparam logic [3:0]  DEG_RESET = 4'd3;
  localparam logic [15:0] TOL_RESET = 16'd7;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_EVAL = 1'b1;

  typedef logic [CIDX_W-1:0] cidx_t;
  typedef logic [UPC_W-1:0]  upc_t;

  // Register select taken from paddr bit 2 (registers at byte offsets 0 and 4)
  typedef enum logic {
    REG_DEGREE    = 1'b0,
    REG_TOLERANCE = 1'b1
  } reg_e;

  // Datapath operation of one microcode step
  typedef enum logic [2:0] {
    OP_IDLE,
    OP_INIT,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_PROD,
    OP_ADD,
    OP_DONE
  } uop_e;

  // Jump condition of one microcode step
  typedef enum logic [2:0] {
    COND_NEVER,
    COND_START,
    COND_IDX_ZERO,
    COND_IDX_NZ,
    COND_OUT_FREE
  } cond_e;

  typedef struct packed {
    uop_e  op;
    cond_e cond;
    upc_t  target;
    logic  hold;
  } uword_t;

  typedef struct packed {
    uop_e op;
    logic start;
  } dp_ctrl_t;

  typedef struct packed {
    logic idx_zero;
  } dp_stat_t;

  localparam upc_t UPC_WAIT   = 3'd0;
  localparam upc_t UPC_INIT   = 3'd1;
  localparam upc_t UPC_MUL_LO = 3'd2;
  localparam upc_t UPC_MUL_HI = 3'd3;
  localparam upc_t UPC_PROD   = 3'd4;
  localparam upc_t UPC_ADD    = 3'd5;
  localparam upc_t UPC_DONE   = 3'd6;

  // Jump to target when the condition holds, else hold or advance
  function automatic uword_t ucode_rom(upc_t pc);
    uword_t w;
    unique case (pc)
      UPC_WAIT:   w = '{op: OP_IDLE,   cond: COND_START,    target: UPC_INIT,   hold: 1'b1};
      UPC_INIT:   w = '{op: OP_INIT,   cond: COND_IDX_ZERO, target: UPC_DONE,   hold: 1'b0};
      UPC_MUL_LO: w = '{op: OP_MUL_LO, cond: COND_NEVER,    target: UPC_WAIT,   hold: 1'b0};
      UPC_MUL_HI: w = '{op: OP_MUL_HI, cond: COND_NEVER,    target: UPC_WAIT,   hold: 1'b0};
      UPC_PROD:   w = '{op: OP_PROD,   cond: COND_NEVER,    target: UPC_WAIT,   hold: 1'b0};
      UPC_ADD:    w = '{op: OP_ADD,    cond: COND_IDX_NZ,   target: UPC_MUL_LO, hold: 1'b0};
      UPC_DONE:   w = '{op: OP_DONE,   cond: COND_OUT_FREE, target: UPC_WAIT,   hold: 1'b1};
      default:    w = '{op: OP_IDLE,   cond: COND_NEVER,    target: UPC_WAIT,   hold: 1'b0};
    endcase
    return w;
  endfunction

endpackage

// File: hdl/hpr_datapath.sv
// ----------------------------------------------------------------------------
// hpr_datapath
// Accumulator, shared 33x32 multiplier and saturating arithmetic for one
// Horner step, driven one operation per cycle by the sequencer.
// ----------------------------------------------------------------------------
module hpr_datapath (
  input  logic                  clk_i,
  input  hpr_pkg::dp_ctrl_t     ctrl_i,
  input  logic signed [31:0]    x_value_i,
  input  hpr_pkg::cidx_t        degree_i,
  input  logic signed [15:0]    coeff_i,
  input  logic [15:0]           tolerance_i,
  output hpr_pkg::cidx_t        idx_o,
  output hpr_pkg::dp_stat_t     stat_o,
  output logic signed [63:0]    acc_o,
  output logic                  ovf_o,
  output logic                  is_root_o
);
  import hpr_pkg::*;

  logic signed [31:0] x_q;
  logic signed [63:0] acc_q, acc_d;
  logic               ovf_q, ovf_d;
  cidx_t              idx_q, idx_d;
  logic signed [64:0] pp_lo_q, pp_hi_q;

  logic signed [32:0] mul_a;
  logic signed [64:0] mul_p;
  logic [95:0]        prod;
  logic               prod_sat;
  logic [63:0]        coeff_q16;
  logic [63:0]        sum;
  logic               sum_sat;
  logic [63:0]        mag;

  // Low half unsigned, high half signed: acc*x = hi*x*2^32 + lo*x
  assign mul_a = (ctrl_i.op == OP_MUL_LO) ? $signed({1'b0, acc_q[31:0]})
                                          : $signed({acc_q[63], acc_q[63:32]});
  assign mul_p = mul_a * x_q;

  assign prod     = {pp_hi_q[63:0], 32'b0} + {{31{pp_lo_q[64]}}, pp_lo_q};
  assign prod_sat = !((&prod[95:79]) || !(|prod[95:79]));

  assign coeff_q16 = {{32{coeff_i[15]}}, coeff_i, 16'b0};
  assign sum       = acc_q + coeff_q16;
  assign sum_sat   = (acc_q[63] == coeff_q16[63]) && (sum[63] != acc_q[63]);

  assign mag       = acc_q[63] ? (64'd0 - acc_q) : acc_q;
  assign is_root_o = mag < {48'b0, tolerance_i};

  always_comb begin
    acc_d = acc_q;
    ovf_d = ovf_q;
    idx_d = idx_q;
    case (ctrl_i.op)
      OP_IDLE: begin
        if (ctrl_i.start) begin
          idx_d = degree_i;
          ovf_d = 1'b0;
        end
      end
      OP_INIT: acc_d = coeff_q16;
      OP_PROD: begin
        idx_d = idx_q - cidx_t'(1);
        if (prod_sat) begin
          ovf_d = 1'b1;
          acc_d = prod[95] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
        end else begin
          acc_d = prod[79:16];
        end
      end
      OP_ADD: begin
        if (sum_sat) begin
          ovf_d = 1'b1;
          acc_d = acc_q[63] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
        end else begin
          acc_d = sum;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    ovf_q <= ovf_d;
    idx_q <= idx_d;
    if (ctrl_i.op == OP_IDLE && ctrl_i.start) begin
      x_q <= x_value_i;
    end
    if (ctrl_i.op == OP_MUL_LO) begin
      pp_lo_q <= mul_p;
    end
    if (ctrl_i.op == OP_MUL_HI) begin
      pp_hi_q <= mul_p;
    end
  end

  assign idx_o           = idx_q;
  assign stat_o.idx_zero = (idx_q == '0);
  assign acc_o           = acc_q;
  assign ovf_o           = ovf_q;

endmodule

// File: hdl/horner_polynomial_root_check.sv
// ----------------------------------------------------------------------------
// horner_polynomial_root_check
// Polynomial evaluation by Horner's rule with a root flag, run by a microcode
// sequencer over a coefficient table.
// ----------------------------------------------------------------------------
// Evaluation: four microcode steps per Horner step around the one shared
//   33x32 multiplier. A load gives no result and leaves the input ready.
//   A new evaluation is accepted only once the previous result has been
//   loaded into the result register.
// Reset: asynchronous, active low; clears the table, sets degree 3 and
//   tolerance 7, returns the sequencer to its wait step and drops the result.
module horner_polynomial_root_check (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // input transaction
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      mode_i,
  input  logic [3:0]                coeff_index_i,
  input  logic signed [15:0]        coeff_value_i,
  input  logic signed [31:0]        x_value_i,
  // result transaction
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [63:0]        poly_value_o,
  output logic                      is_root_o,
  output logic                      overflow_o,
  // configuration port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [hpr_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import hpr_pkg::*;

  // Configuration registers
  logic [3:0]  degree_q;
  logic [15:0] tolerance_q;
  reg_e        reg_sel;
  logic        cfg_write;

  // Coefficient table, cleared by reset
  logic signed [15:0] coeff_table_q [COEFF_COUNT];

  // Sequencer
  upc_t   upc_q, upc_d;
  uword_t uword;
  logic   cond_hit;

  // Handshake helpers
  logic in_accept;
  logic start;
  logic out_free;
  logic out_load;

  // Datapath links
  dp_ctrl_t           dp_ctrl;
  dp_stat_t           dp_stat;
  cidx_t              dp_idx;
  cidx_t              degree_eff;
  logic signed [63:0] dp_acc;
  logic               dp_ovf;
  logic               dp_is_root;

  // Result register
  logic               out_valid_q;
  logic signed [63:0] poly_value_q;
  logic               is_root_q;
  logic               overflow_q;

  // --------------------------------------------------------------------------
  // Configuration: two registers decoded on address bit 2, byte lanes ignored
  // --------------------------------------------------------------------------
  assign reg_sel   = reg_e'(paddr[2]);
  assign cfg_write = psel && penable && pwrite;
  assign pready    = 1'b1;

  always_comb begin
    unique case (reg_sel)
      REG_DEGREE:    prdata = {28'b0, degree_q};
      REG_TOLERANCE: prdata = {16'b0, tolerance_q};
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      degree_q    <= DEG_RESET;
      tolerance_q <= TOL_RESET;
    end else if (cfg_write) begin
      if (reg_sel == REG_DEGREE) begin
        degree_q <= pwdata[3:0];
      end else begin
        tolerance_q <= pwdata[15:0];
      end
    end
  end

  // Clamp the degree to the last table entry
  assign degree_eff = (32'(degree_q) > COEFF_COUNT - 1) ? cidx_t'(COEFF_COUNT - 1)
                                                         : cidx_t'(degree_q);

  // --------------------------------------------------------------------------
  // Input side: ready only in the wait step of the microcode
  // --------------------------------------------------------------------------
  assign uword      = ucode_rom(upc_q);
  assign in_ready_o = (uword.op == OP_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;
  assign start      = in_accept && (mode_i == MODE_EVAL);

  // Load transaction: write one entry, drop writes beyond the table
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < COEFF_COUNT; i++) begin
        coeff_table_q[i] <= '0;
      end
    end else if (in_accept && (mode_i == MODE_LOAD) && (32'(coeff_index_i) < COEFF_COUNT)) begin
      coeff_table_q[cidx_t'(coeff_index_i)] <= coeff_value_i;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer: jump on condition, else hold or advance
  // --------------------------------------------------------------------------
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    case (uword.cond)
      COND_START:    cond_hit = start;
      COND_IDX_ZERO: cond_hit = dp_stat.idx_zero;
      COND_IDX_NZ:   cond_hit = !dp_stat.idx_zero;
      COND_OUT_FREE: cond_hit = out_free;
      default:       cond_hit = 1'b0;
    endcase
    if (cond_hit) begin
      upc_d = uword.target;
    end else if (uword.hold) begin
      upc_d = upc_q;
    end else begin
      upc_d = upc_q + upc_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= UPC_WAIT;
    end else begin
      upc_q <= upc_d;
    end
  end

  // --------------------------------------------------------------------------
  // Datapath
  // --------------------------------------------------------------------------
  assign dp_ctrl.op    = uword.op;
  assign dp_ctrl.start = start;

  hpr_datapath u_datapath (
    .clk_i       (clk_i),
    .ctrl_i      (dp_ctrl),
    .x_value_i   (x_value_i),
    .degree_i    (degree_eff),
    .coeff_i     (coeff_table_q[dp_idx]),
    .tolerance_i (tolerance_q),
    .idx_o       (dp_idx),
    .stat_o      (dp_stat),
    .acc_o       (dp_acc),
    .ovf_o       (dp_ovf),
    .is_root_o   (dp_is_root)
  );

  // --------------------------------------------------------------------------
  // Result register: load in the done step once the previous result is taken
  // --------------------------------------------------------------------------
  assign out_load = (uword.op == OP_DONE) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      poly_value_q <= dp_acc;
      is_root_q    <= dp_is_root;
      overflow_q   <= dp_ovf;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign poly_value_o = poly_value_q;
  assign is_root_o    = is_root_q;
  assign overflow_o   = overflow_q;

endmodule

// File: hdl/hpr_checker.sv
// ----------------------------------------------------------------------------
// hpr_checker
// Port-level checks of the Horner polynomial root check, bound to the top.
// ----------------------------------------------------------------------------
module hpr_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               mode_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [63:0] poly_value_o,
  input logic               is_root_o
);
  import hpr_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(poly_value_o))
    else $error("result changed while stalled");

  // An accepted evaluate transaction closes the input
  a_eval_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (mode_i == MODE_EVAL) |=> !in_ready_o)
    else $error("input accepted during evaluation");

  // A result appears only after the sequencer has left its wait step
  a_rise_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result raised while waiting for input");

  // A root lies within the 16-bit tolerance, so its upper bits are sign only
  a_root_small: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_root_o |-> (&poly_value_o[63:16]) || !(|poly_value_o[63:16]))
    else $error("root flagged on a large value");

endmodule

bind horner_polynomial_root_check hpr_checker u_hpr_checker (.*);
